/* src/tgp_pkg.sv */
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared widths, constants and helpers of the two-group RGB partition block.
// ----------------------------------------------------------------------------
`default_nettype none

package tgp_pkg;

	localparam int COORD_W    = 8;
	localparam int POINT_W    = 3 * COORD_W;
	localparam int COST_W     = 38;
	localparam int CFG_W      = 2;
	localparam int MAX_POINTS = 64;
	localparam int FRAC_BITS  = 16;
	localparam int DVD_W      = 64;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int NORMAL_W   = 18;
	localparam int DOT_W      = 30;
	localparam int SQ_W       = 2 * COORD_W;

	localparam logic [COST_W-1:0] INFINITY      = '1;
	localparam logic [CFG_W-1:0]  GROUPS_RESET  = 2'd2;
	localparam logic [CFG_W-1:0]  ONE_GROUP     = 2'd1;

	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

	// One color channel of a packed point: red in the low byte.
	function automatic logic [COORD_W-1:0] chan(input logic [POINT_W-1:0] p,
		input logic [1:0] ch);
		return p[COORD_W*ch +: COORD_W];
	endfunction

endpackage

`default_nettype wire

/* src/tgp_ifs.sv */
// ----------------------------------------------------------------------------
// tgp_ifs
// Valid/ready channel interfaces: point input, cost output, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgp_point_if;
	logic                         valid;
	logic                         ready;
	logic [tgp_pkg::COORD_W-1:0]  red;
	logic [tgp_pkg::COORD_W-1:0]  green;
	logic [tgp_pkg::COORD_W-1:0]  blue;
	logic                         last;
	modport source (output valid, red, green, blue, last, input ready);
	modport sink   (input valid, red, green, blue, last, output ready);
endinterface

interface tgp_cost_if;
	logic                         valid;
	logic                         ready;
	logic [tgp_pkg::COST_W-1:0]   cost;
	modport source (output valid, cost, input ready);
	modport sink   (input valid, cost, output ready);
endinterface

interface tgp_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tgp_pkg::CFG_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* src/tgp_ram.sv */
// ----------------------------------------------------------------------------
// tgp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/tgp_div.sv */
// ----------------------------------------------------------------------------
// tgp_div
// Restoring divider: one quotient bit per cycle over a 64-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_div #(
	parameter int DIVISOR_W = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tgp_pkg::div_req_t           req,
	input  wire logic [tgp_pkg::DVD_W-1:0]   dividend,
	input  wire logic [DIVISOR_W-1:0]        divisor,
	output tgp_pkg::div_rsp_t                rsp,
	output logic      [tgp_pkg::DVD_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(tgp_pkg::DVD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [tgp_pkg::DVD_W-1:0]   quo_q;
	logic [DIVISOR_W-1:0]        rem_q;
	logic [DIVISOR_W-1:0]        dvs_q;
	logic [DIVISOR_W:0]          trial;
	logic                        ge;

	// The remainder stays below the divisor, so the trial fits one extra bit.
	assign trial = {rem_q, quo_q[tgp_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(tgp_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[tgp_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* src/two_group_rgb_min_sse_partition.sv */
// ----------------------------------------------------------------------------
// two_group_rgb_min_sse_partition
// Minimum two-group (or one-group) squared-deviation cost of an RGB point set.
//
// Points arrive on pts, one transaction per cycle while pts.ready is high,
// and are written into a point RAM; points beyond MAX_POINTS are dropped. The
// transaction with last set ends the set and starts the computation, during
// which pts.ready is low. cfg writes the group count (1: whole-set cost, else
// best plane split); it is always ready. It must be written only while the
// block is idle; the block itself does not enforce this.
// One cost transaction per set appears on res, held in an output register;
// if the receiver stalls, a finished result waits there and the next set
// can be loaded, but the next computation holds its result until it drains.
// Two-group mode tries all 8 assignments of each point triple to the two
// groups; the divider and the single multiplier are shared by every step.
// In two-group mode, fewer than three points give a cost of 0.
// Reset empties the store, sets the group count to 2 and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module two_group_rgb_min_sse_partition (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tgp_point_if.sink   pts,
	tgp_cost_if.source  res,
	tgp_cfg_if.sink     cfg
);

	localparam int MAX_POINTS = tgp_pkg::MAX_POINTS;
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int SW   = tgp_pkg::COORD_W + CW;
	localparam int QW   = tgp_pkg::SQ_W + CW;
	localparam int NW   = QW + CW + 2;
	localparam int MAW  = NW + 1;
	localparam int MBW  = (SW + 1 > tgp_pkg::NORMAL_W) ? SW + 1 : tgp_pkg::NORMAL_W;
	localparam int PW   = MAW + MBW;
	localparam int DW   = 2 * CW;
	localparam int DTW  = tgp_pkg::DOT_W;
	localparam int NRW  = tgp_pkg::NORMAL_W;
	localparam int DFW  = tgp_pkg::DIFF_W;
	localparam int PTW  = tgp_pkg::POINT_W;
	localparam int CSW  = tgp_pkg::COST_W;
	localparam int XW   = tgp_pkg::DVD_W;

	typedef enum logic [4:0] {
		S_LOAD, S_TRI_A, S_TRI_B, S_TRI_C, S_TRI_D, S_CROSS, S_TSQ,
		S_M_RD, S_M_DOT, S_M_SQ, S_MASK, S_NUM, S_PAIR,
		S_DIV_GO, S_DIV_WAIT, S_FIN, S_OUT
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          cnt_q, n_q, i_q, j_q, k_q, m_q;
	logic [3:0]             step_q;
	logic [2:0]             mask_q;
	logic                   side_q;
	logic                   one_q;
	logic [tgp_pkg::CFG_W-1:0] gcnt_q;
	logic                   out_valid_q;
	logic [CSW-1:0]         cost_q;
	logic [CSW-1:0]         res_q;

	logic [PTW-1:0]         pi_q, pj_q, pk_q;
	logic signed [NRW-1:0]  nr_q [3];
	logic signed [DTW-1:0]  d_q;
	logic [tgp_pkg::SQ_W-1:0] tq_q [3][3];
	logic [CW-1:0]          grp_c_q [2];
	logic [SW-1:0]          grp_s_q [2][3];
	logic [QW-1:0]          grp_sq_q [2][3];
	logic [CW-1:0]          g2_c_q [2];
	logic [SW-1:0]          g2_s_q [2][3];
	logic [QW-1:0]          g2_sq_q [2][3];
	logic [NW-1:0]          na_q, nb_q;
	logic [XW-1:0]          num_q;
	logic [DW-1:0]          den_q;
	logic [CSW-1:0]         best_q;

	logic                   accept_in;
	logic [CW-1:0]          cnt_nxt;
	logic [PTW-1:0]         rdata;
	logic [AW-1:0]          raddr;
	logic [PTW-1:0]         tri_p [3];
	logic signed [DFW-1:0]  v1 [3];
	logic signed [DFW-1:0]  v2 [3];
	logic signed [DFW-1:0]  diff [3];
	logic signed [MAW-1:0]  mul_a;
	logic signed [MBW-1:0]  mul_b;
	logic signed [PW-1:0]   prod;
	logic signed [DTW-1:0]  dot_sum;
	logic [1:0]             cr_a, cr_b;
	logic [1:0]             tsq_t, tsq_ch;
	logic                   num_g, num_sub;
	logic [3:0]             num_r;
	logic [1:0]             num_ch;
	logic [CW-1:0]          c_n [2];
	logic [SW-1:0]          s_n [2][3];
	logic [QW-1:0]          q_n [2][3];
	logic [CW-1:0]          ca, cb;
	logic [CSW-1:0]         fin_val, best_next;
	logic                   adv_k, adv_j, adv_i;
	tgp_pkg::div_req_t      div_req;
	tgp_pkg::div_rsp_t      div_rsp;
	logic [XW-1:0]          quot;
	logic [XW-1:0]          dividend;

	assign accept_in = pts.valid && pts.ready;
	assign pts.ready = (state_q == S_LOAD);
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.cost  = cost_q;
	assign cnt_nxt   = cnt_q + CW'(cnt_q < CW'(MAX_POINTS));

	tgp_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (accept_in && (cnt_q < CW'(MAX_POINTS))),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({pts.blue, pts.green, pts.red}),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		case (state_q)
			S_TRI_A: raddr = i_q[AW-1:0];
			S_TRI_B: raddr = j_q[AW-1:0];
			S_TRI_C: raddr = k_q[AW-1:0];
			default: raddr = m_q[AW-1:0];
		endcase
	end

	assign tri_p[0] = pi_q;
	assign tri_p[1] = pj_q;
	assign tri_p[2] = pk_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			v1[ch]   = $signed({1'b0, tgp_pkg::chan(pj_q, 2'(ch))}) -
			           $signed({1'b0, tgp_pkg::chan(pi_q, 2'(ch))});
			v2[ch]   = $signed({1'b0, tgp_pkg::chan(pk_q, 2'(ch))}) -
			           $signed({1'b0, tgp_pkg::chan(pi_q, 2'(ch))});
			diff[ch] = $signed({1'b0, tgp_pkg::chan(rdata, 2'(ch))}) -
			           $signed({1'b0, tgp_pkg::chan(pi_q, 2'(ch))});
		end
	end

	// Cross product terms in step order: each component is a plus and a minus product.
	always_comb begin
		case (step_q)
			4'd0:    begin cr_a = 2'd1; cr_b = 2'd2; end
			4'd1:    begin cr_a = 2'd2; cr_b = 2'd1; end
			4'd2:    begin cr_a = 2'd2; cr_b = 2'd0; end
			4'd3:    begin cr_a = 2'd0; cr_b = 2'd2; end
			4'd4:    begin cr_a = 2'd0; cr_b = 2'd1; end
			default: begin cr_a = 2'd1; cr_b = 2'd0; end
		endcase
	end

	always_comb begin
		case (step_q) inside
			[4'd0:4'd2]: tsq_t = 2'd0;
			[4'd3:4'd5]: tsq_t = 2'd1;
			default:     tsq_t = 2'd2;
		endcase
		tsq_ch  = 2'(step_q - {1'b0, tsq_t, 1'b0} - {2'b00, tsq_t});
		num_g   = (step_q >= 4'd6);
		num_r   = num_g ? step_q - 4'd6 : step_q;
		num_ch  = num_r[2:1];
		num_sub = num_r[0];
	end

	assign ca = g2_c_q[0];
	assign cb = g2_c_q[1];

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CROSS: begin
				mul_a = MAW'(v1[cr_a]);
				mul_b = MBW'(v2[cr_b]);
			end
			S_TSQ: begin
				mul_a = MAW'({1'b0, tgp_pkg::chan(tri_p[tsq_t], tsq_ch)});
				mul_b = MBW'({1'b0, tgp_pkg::chan(tri_p[tsq_t], tsq_ch)});
			end
			S_M_DOT: begin
				mul_a = MAW'(nr_q[step_q[1:0]]);
				mul_b = MBW'(diff[step_q[1:0]]);
			end
			S_M_SQ: begin
				mul_a = MAW'({1'b0, tgp_pkg::chan(rdata, step_q[1:0])});
				mul_b = MBW'({1'b0, tgp_pkg::chan(rdata, step_q[1:0])});
			end
			S_NUM: begin
				if (num_sub) begin
					mul_a = MAW'({1'b0, g2_s_q[num_g][num_ch]});
					mul_b = MBW'({1'b0, g2_s_q[num_g][num_ch]});
				end else begin
					mul_a = MAW'({1'b0, g2_sq_q[num_g][num_ch]});
					mul_b = MBW'({1'b0, g2_c_q[num_g]});
				end
			end
			S_PAIR: begin
				case (step_q)
					4'd0: begin
						mul_a = MAW'({1'b0, na_q});
						mul_b = MBW'({1'b0, cb});
					end
					4'd1: begin
						mul_a = MAW'({1'b0, nb_q});
						mul_b = MBW'({1'b0, ca});
					end
					default: begin
						mul_a = MAW'({1'b0, ca});
						mul_b = MBW'({1'b0, cb});
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign dot_sum = ((step_q == 4'd0) ? DTW'(0) : d_q) + DTW'(prod);

	// Group totals with the three triple points placed by the assignment mask.
	always_comb begin
		for (int g = 0; g < 2; g++) begin
			c_n[g] = grp_c_q[g];
			for (int ch = 0; ch < 3; ch++) begin
				s_n[g][ch] = grp_s_q[g][ch];
				q_n[g][ch] = grp_sq_q[g][ch];
			end
			if (!one_q) begin
				for (int t = 0; t < 3; t++) begin
					if (mask_q[t] == 1'(g)) begin
						c_n[g] = c_n[g] + CW'(1);
						for (int ch = 0; ch < 3; ch++) begin
							s_n[g][ch] = s_n[g][ch] +
								SW'(tgp_pkg::chan(tri_p[t], 2'(ch)));
							q_n[g][ch] = q_n[g][ch] + QW'(tq_q[t][ch]);
						end
					end
				end
			end
		end
	end

	assign dividend     = (num_q << tgp_pkg::FRAC_BITS) + XW'(den_q >> 1);
	assign div_req.start = (state_q == S_DIV_GO);

	tgp_div #(.DIVISOR_W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (dividend),
		.divisor  (den_q),
		.rsp      (div_rsp),
		.quotient (quot)
	);

	always_comb begin
		if (den_q == '0) begin
			fin_val = '0;
		end else if (quot > XW'(tgp_pkg::INFINITY)) begin
			fin_val = tgp_pkg::INFINITY;
		end else begin
			fin_val = quot[CSW-1:0];
		end
		best_next = (fin_val < best_q) ? fin_val : best_q;
	end

	assign adv_k = ((CW+1)'(k_q) + (CW+1)'(1)) < (CW+1)'(n_q);
	assign adv_j = ((CW+1)'(j_q) + (CW+1)'(2)) < (CW+1)'(n_q);
	assign adv_i = ((CW+1)'(i_q) + (CW+1)'(3)) < (CW+1)'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			m_q         <= '0;
			step_q      <= '0;
			mask_q      <= '0;
			side_q      <= 1'b0;
			one_q       <= 1'b0;
			gcnt_q      <= tgp_pkg::GROUPS_RESET;
			out_valid_q <= 1'b0;
			cost_q      <= '0;
			res_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				gcnt_q <= cfg.data;
			end
			// A waiting result is replaced in the same cycle that it drains.
			if (state_q == S_OUT && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept_in) begin
						if (pts.last) begin
							cnt_q  <= '0;
							n_q    <= cnt_nxt;
							one_q  <= (gcnt_q == tgp_pkg::ONE_GROUP);
							m_q    <= '0;
							i_q    <= '0;
							j_q    <= CW'(1);
							k_q    <= CW'(2);
							step_q <= '0;
							mask_q <= '0;
							if (gcnt_q == tgp_pkg::ONE_GROUP) begin
								state_q <= S_M_RD;
							end else if (cnt_nxt < CW'(3)) begin
								res_q   <= '0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_TRI_A;
							end
						end else begin
							cnt_q <= cnt_nxt;
						end
					end
				end
				S_TRI_A: state_q <= S_TRI_B;
				S_TRI_B: state_q <= S_TRI_C;
				S_TRI_C: state_q <= S_TRI_D;
				S_TRI_D: begin
					step_q  <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					if (step_q == 4'd5) begin
						step_q  <= '0;
						state_q <= S_TSQ;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_TSQ: begin
					if (step_q == 4'd8) begin
						step_q  <= '0;
						m_q     <= '0;
						state_q <= S_M_RD;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_M_RD: begin
					step_q <= '0;
					if (m_q == n_q) begin
						state_q <= S_MASK;
					end else if (one_q) begin
						side_q  <= 1'b0;
						state_q <= S_M_SQ;
					end else if (m_q == i_q || m_q == j_q || m_q == k_q) begin
						m_q <= m_q + CW'(1);
					end else begin
						state_q <= S_M_DOT;
					end
				end
				S_M_DOT: begin
					if (step_q == 4'd2) begin
						step_q <= '0;
						if (dot_sum == '0) begin
							// A point on the plane joins neither group.
							m_q     <= m_q + CW'(1);
							state_q <= S_M_RD;
						end else begin
							side_q  <= !dot_sum[DTW-1];
							state_q <= S_M_SQ;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_M_SQ: begin
					if (step_q == 4'd2) begin
						step_q  <= '0;
						m_q     <= m_q + CW'(1);
						state_q <= S_M_RD;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_MASK: begin
					step_q  <= '0;
					state_q <= S_NUM;
				end
				S_NUM: begin
					if (step_q == 4'd11) begin
						step_q  <= '0;
						state_q <= S_PAIR;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_PAIR: begin
					if (ca == '0 || cb == '0 || step_q == 4'd2) begin
						step_q  <= '0;
						state_q <= S_DIV_GO;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (one_q) begin
						res_q   <= fin_val;
						state_q <= S_OUT;
					end else if (mask_q != 3'd7) begin
						mask_q  <= mask_q + 3'd1;
						state_q <= S_MASK;
					end else begin
						mask_q <= '0;
						if (adv_k) begin
							k_q     <= k_q + CW'(1);
							state_q <= S_TRI_A;
						end else if (adv_j) begin
							j_q     <= j_q + CW'(1);
							k_q     <= j_q + CW'(2);
							state_q <= S_TRI_A;
						end else if (adv_i) begin
							i_q     <= i_q + CW'(1);
							j_q     <= i_q + CW'(2);
							k_q     <= i_q + CW'(3);
							state_q <= S_TRI_A;
						end else begin
							res_q   <= best_next;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || res.ready) begin
						cost_q  <= res_q;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				if (accept_in && pts.last) begin
					best_q   <= tgp_pkg::INFINITY;
					grp_c_q  <= '{default: '0};
					grp_s_q  <= '{default: '{default: '0}};
					grp_sq_q <= '{default: '{default: '0}};
				end
			end
			S_TRI_B: pi_q <= rdata;
			S_TRI_C: pj_q <= rdata;
			S_TRI_D: begin
				pk_q <= rdata;
				nr_q <= '{default: '0};
			end
			S_CROSS: begin
				if (step_q[0]) begin
					nr_q[step_q[2:1]] <= nr_q[step_q[2:1]] - NRW'(prod);
				end else begin
					nr_q[step_q[2:1]] <= nr_q[step_q[2:1]] + NRW'(prod);
				end
			end
			S_TSQ: begin
				tq_q[tsq_t][tsq_ch] <= tgp_pkg::SQ_W'(prod);
				grp_c_q  <= '{default: '0};
				grp_s_q  <= '{default: '{default: '0}};
				grp_sq_q <= '{default: '{default: '0}};
			end
			S_M_DOT: d_q <= dot_sum;
			S_M_SQ: begin
				grp_sq_q[side_q][step_q[1:0]] <= grp_sq_q[side_q][step_q[1:0]] + QW'(prod);
				if (step_q == 4'd0) begin
					grp_c_q[side_q] <= grp_c_q[side_q] + CW'(1);
					for (int ch = 0; ch < 3; ch++) begin
						grp_s_q[side_q][ch] <= grp_s_q[side_q][ch] +
							SW'(tgp_pkg::chan(rdata, 2'(ch)));
					end
				end
			end
			S_MASK: begin
				g2_c_q  <= c_n;
				g2_s_q  <= s_n;
				g2_sq_q <= q_n;
				na_q    <= '0;
				nb_q    <= '0;
			end
			S_NUM: begin
				// c*Q - S*S per channel, accumulated into the group numerator.
				if (num_g) begin
					nb_q <= num_sub ? nb_q - NW'(prod) : nb_q + NW'(prod);
				end else begin
					na_q <= num_sub ? na_q - NW'(prod) : na_q + NW'(prod);
				end
			end
			S_PAIR: begin
				if (ca == '0) begin
					num_q <= XW'(nb_q);
					den_q <= DW'(cb);
				end else if (cb == '0) begin
					num_q <= XW'(na_q);
					den_q <= DW'(ca);
				end else begin
					case (step_q)
						4'd0:    num_q <= XW'(prod);
						4'd1:    num_q <= num_q + XW'(prod);
						default: den_q <= DW'(prod);
					endcase
				end
			end
			S_FIN: begin
				if (!one_q) begin
					best_q <= best_next;
				end
			end
			default: begin
			end
		endcase
	end

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count exceeds store depth");

	ap_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_in && pts.last) |=> !pts.ready)
		else $error("block ready right after the last point");

	ap_triple_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M_DOT) |-> (i_q < j_q && j_q < k_q && k_q < n_q))
		else $error("triple indices out of order");

	ap_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside the wait state");

endmodule

`default_nettype wire
